### rtl/core/dlt_pkg.sv
package dlt_pkg;

    localparam int LINK_W         = 10;
    localparam int NODE_SLOTS_DEF = 1024;

    typedef enum logic [1:0] {
        KIND_REMOVE     = 2'd0,
        KIND_INS_BEFORE = 2'd1,
        KIND_INS_AFTER  = 2'd2,
        KIND_QUERY      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LINK_W-1:0]  target_node;
        logic [LINK_W-1:0]  placed_node;
    } dlt_req_t;

    typedef struct packed {
        logic [LINK_W-1:0]  prev_node;
        logic [LINK_W-1:0]  next_node;
    } dlt_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC1,
        ST_EXEC2
    } state_t;

endpackage

### rtl/core/doubly_linked_list_table.sv
// Channel   | Signals                       | Handshake
// ----------+-------------------------------+-----------------------------------
// request   | start, busy, req (dlt_req_t)  | taken when start && !busy
// result    | result_valid, result          | one-cycle strobe, queries only
//
// After reset both link RAMs are swept to zero, with busy high throughout.
// Remove and insert: accept, read, two write steps; a query: accept, read, result.
// The fixed schedule comes from the single port on each link RAM.
// A query result is registered and shown for one cycle; the receiver cannot stall,
// and the next request may be taken while it is shown.
module doubly_linked_list_table
    import dlt_pkg::*;
    #(
        parameter int NODE_SLOTS = NODE_SLOTS_DEF
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        start,
        output logic        busy,
        input  dlt_req_t    req,
        output logic        result_valid,
        output dlt_result_t result
    );

    localparam int ADDR_W = $clog2(NODE_SLOTS);

    function automatic logic is_node(input logic [LINK_W-1:0] n);
        return (n != '0) && (32'(n) < 32'(NODE_SLOTS));
    endfunction

    function automatic logic [ADDR_W-1:0] node_addr(input logic [LINK_W-1:0] n);
        return ADDR_W'(n);
    endfunction

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    kind_t              kind_reg;
    logic [LINK_W-1:0]  tgt_reg, plc_reg;
    logic               ok_reg;
    logic [LINK_W-1:0]  before_reg, before_next;
    logic [LINK_W-1:0]  after_reg, after_next;
    dlt_result_t        result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic               accept;
    logic               req_ok;
    logic               clr_done;

    logic               prev_we, next_we;
    logic [ADDR_W-1:0]  prev_addr, next_addr;
    logic [LINK_W-1:0]  prev_wdata, next_wdata;
    logic [LINK_W-1:0]  prev_rdata, next_rdata;

    logic [LINK_W-1:0]  ins_before, ins_after, back_node;

    dlt_ram
        #(
            .WIDTH (LINK_W),
            .DEPTH (NODE_SLOTS)
        )
        u_prev_ram
        (
            .clk   (clk),
            .we    (prev_we),
            .addr  (prev_addr),
            .wdata (prev_wdata),
            .rdata (prev_rdata)
        );

    dlt_ram
        #(
            .WIDTH (LINK_W),
            .DEPTH (NODE_SLOTS)
        )
        u_next_ram
        (
            .clk   (clk),
            .we    (next_we),
            .addr  (next_addr),
            .wdata (next_wdata),
            .rdata (next_rdata)
        );

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign clr_done     = (clr_reg == ADDR_W'(NODE_SLOTS - 1));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        case (req.kind)
            KIND_INS_BEFORE,
            KIND_INS_AFTER:  req_ok = is_node(req.target_node) && is_node(req.placed_node);
            default:         req_ok = is_node(req.target_node);
        endcase
    end

    // neighbors of the placed node; back_node is its prev link as seen after the
    // first back-pointer write (itself when placed beside itself)
    assign ins_before = (kind_reg == KIND_INS_BEFORE) ? prev_rdata : tgt_reg;
    assign ins_after  = (kind_reg == KIND_INS_BEFORE) ? tgt_reg : next_rdata;
    assign back_node  = (after_reg == plc_reg) ? plc_reg : before_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC1;
            end
            ST_EXEC1:
            begin
                state_next = (kind_reg == KIND_QUERY) ? ST_IDLE : ST_EXEC2;
            end
            ST_EXEC2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prev_we           = 1'b0;
        next_we           = 1'b0;
        prev_addr         = node_addr(tgt_reg);
        next_addr         = node_addr(tgt_reg);
        prev_wdata        = '0;
        next_wdata        = '0;
        before_next       = before_reg;
        after_next        = after_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                prev_we   = 1'b1;
                next_we   = 1'b1;
                prev_addr = clr_reg;
                next_addr = clr_reg;
            end
            ST_EXEC1:
            begin
                case (kind_reg)
                    KIND_REMOVE:
                    begin
                        if (ok_reg && (prev_rdata != '0))
                        begin
                            next_we    = 1'b1;
                            next_addr  = node_addr(prev_rdata);
                            next_wdata = next_rdata;
                        end
                        if (ok_reg && (next_rdata != '0))
                        begin
                            prev_we    = 1'b1;
                            prev_addr  = node_addr(next_rdata);
                            prev_wdata = prev_rdata;
                        end
                    end
                    KIND_INS_BEFORE,
                    KIND_INS_AFTER:
                    begin
                        before_next = ins_before;
                        after_next  = ins_after;
                        if (ok_reg)
                        begin
                            prev_we    = 1'b1;
                            next_we    = 1'b1;
                            prev_addr  = node_addr(plc_reg);
                            next_addr  = node_addr(plc_reg);
                            prev_wdata = ins_before;
                            next_wdata = ins_after;
                        end
                    end
                    default:
                    begin
                        result_valid_next     = 1'b1;
                        result_next.prev_node = ok_reg ? prev_rdata : '0;
                        result_next.next_node = ok_reg ? next_rdata : '0;
                    end
                endcase
            end
            ST_EXEC2:
            begin
                case (kind_reg)
                    KIND_REMOVE:
                    begin
                        prev_we = ok_reg;
                        next_we = ok_reg;
                    end
                    KIND_INS_BEFORE,
                    KIND_INS_AFTER:
                    begin
                        if (ok_reg && (after_reg != '0))
                        begin
                            prev_we    = 1'b1;
                            prev_addr  = node_addr(after_reg);
                            prev_wdata = plc_reg;
                        end
                        if (ok_reg && (back_node != '0))
                        begin
                            next_we    = 1'b1;
                            next_addr  = node_addr(back_node);
                            next_wdata = plc_reg;
                        end
                    end
                    default:
                    begin
                        prev_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                prev_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            tgt_reg  <= req.target_node;
            plc_reg  <= req.placed_node;
            ok_reg   <= req_ok;
        end
        before_reg <= before_next;
        after_reg  <= after_next;
        result_reg <= result_next;
    end

endmodule

### rtl/core/dlt_ram.sv
module dlt_ram
    #(
        parameter int WIDTH = 10,
        parameter int DEPTH = 1024
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] addr,
        input  logic [WIDTH-1:0]         wdata,
        output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### dv/doubly_linked_list_table_test.sv
`timescale 1ns / 100ps

module doubly_linked_list_table_test;
    import dlt_pkg::*;

    localparam int POOL_HI = 47;

    class link_table_sb;
        bit [LINK_W-1:0] prev_tab [NODE_SLOTS_DEF];
        bit [LINK_W-1:0] next_tab [NODE_SLOTS_DEF];
        dlt_result_t     neighbours_q [$];
        int unsigned     errors;
        int unsigned     compared;
        int unsigned     kind_seen [4];

        function bit is_node(bit [LINK_W-1:0] n);
            return n != 0 && int'(n) < NODE_SLOTS_DEF;
        endfunction

        function bit [LINK_W-1:0] prev_of(bit [LINK_W-1:0] n);
            return is_node(n) ? prev_tab[n] : '0;
        endfunction

        function bit [LINK_W-1:0] next_of(bit [LINK_W-1:0] n);
            return is_node(n) ? next_tab[n] : '0;
        endfunction

        function void put_prev(bit [LINK_W-1:0] n, bit [LINK_W-1:0] v);
            if (is_node(n))
                prev_tab[n] = v;
        endfunction

        function void put_next(bit [LINK_W-1:0] n, bit [LINK_W-1:0] v);
            if (is_node(n))
                next_tab[n] = v;
        endfunction

        function void unlink(bit [LINK_W-1:0] t);
            bit [LINK_W-1:0] b;
            bit [LINK_W-1:0] a;
            b = prev_of(t);
            a = next_of(t);
            if (b != 0)
                put_next(b, a);
            if (a != 0)
                put_prev(a, b);
            put_prev(t, '0);
            put_next(t, '0);
        endfunction

        // placed node's own links first, then neighbours pointed back, reading as we go
        function void splice(bit [LINK_W-1:0] p, bit [LINK_W-1:0] b, bit [LINK_W-1:0] a);
            bit [LINK_W-1:0] n;
            put_prev(p, b);
            put_next(p, a);
            n = next_of(p);
            if (n != 0)
                put_prev(n, p);
            n = prev_of(p);
            if (n != 0)
                put_next(n, p);
        endfunction

        function void note_request(dlt_req_t r);
            dlt_result_t nb;
            bit [LINK_W-1:0] t;
            bit [LINK_W-1:0] p;
            t = r.target_node;
            p = r.placed_node;
            kind_seen[int'(r.kind)]++;
            case (r.kind)
                KIND_REMOVE:
                    if (is_node(t))
                        unlink(t);
                KIND_INS_BEFORE:
                    if (is_node(t) && is_node(p))
                        splice(p, prev_of(t), t);
                KIND_INS_AFTER:
                    if (is_node(t) && is_node(p))
                        splice(p, t, next_of(t));
                default:
                begin
                    nb.prev_node = prev_of(t);
                    nb.next_node = next_of(t);
                    neighbours_q.push_back(nb);
                end
            endcase
        endfunction

        function void check_result(dlt_result_t got);
            dlt_result_t exp_nb;
            if (neighbours_q.size() == 0)
            begin
                $display("%0t: result with no query pending, expected none, actual prev=%0d next=%0d",
                         $time, got.prev_node, got.next_node);
                errors++;
                return;
            end
            exp_nb = neighbours_q.pop_front();
            compared++;
            if (got.prev_node !== exp_nb.prev_node)
            begin
                $display("%0t: prev_node mismatch, expected %0d, actual %0d",
                         $time, exp_nb.prev_node, got.prev_node);
                errors++;
            end
            if (got.next_node !== exp_nb.next_node)
            begin
                $display("%0t: next_node mismatch, expected %0d, actual %0d",
                         $time, exp_nb.next_node, got.next_node);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    dlt_req_t    req = '0;
    logic        result_valid;
    dlt_result_t result;

    link_table_sb sb = new;
    bit           gaps_on = 1'b0;

    doubly_linked_list_table #(.NODE_SLOTS(NODE_SLOTS_DEF)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid === 1'b1)
                sb.check_result(result);
            if (start && busy === 1'b0)
                sb.note_request(req);
        end
    end

    function automatic dlt_req_t make_req(kind_t k, int t, int p);
        dlt_req_t r;
        r.kind        = k;
        r.target_node = t[LINK_W-1:0];
        r.placed_node = p[LINK_W-1:0];
        return r;
    endfunction

    function automatic dlt_req_t noise_req();
        return make_req(kind_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                        $urandom_range(0, 1023));
    endfunction

    // mostly a small pool so lists grow; sometimes the full range and node 0
    function automatic int pick_node();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 0;
        if (r < 12)
            return $urandom_range(1, 1023);
        return $urandom_range(1, POOL_HI);
    endfunction

    function automatic dlt_req_t list_req();
        kind_t k;
        int    t;
        int    p;
        int    c;
        k = kind_t'($urandom_range(0, 3));
        t = pick_node();
        p = pick_node();
        // prefer a detached node for inserts
        if ($urandom_range(0, 99) < 85)
        begin
            for (c = 0; c < 8; c++)
            begin
                p = $urandom_range(1, POOL_HI);
                if (p != t && sb.prev_tab[p] == 0 && sb.next_tab[p] == 0)
                    break;
            end
        end
        return make_req(k, t, p);
    endfunction

    task automatic send_req(input dlt_req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gaps_on && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
            begin
                req <= noise_req();
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(make_req(KIND_QUERY, 0, 1023));
        send_req(make_req(KIND_QUERY, 1023, 0));
        send_req(make_req(KIND_INS_AFTER, 1, 1023));
        send_req(make_req(KIND_INS_BEFORE, 1023, 512));
        send_req(make_req(KIND_QUERY, 1, 0));
        send_req(make_req(KIND_QUERY, 512, 0));
        send_req(make_req(KIND_QUERY, 1023, 0));
        send_req(make_req(KIND_INS_AFTER, 0, 5));
        send_req(make_req(KIND_INS_BEFORE, 5, 0));
        send_req(make_req(KIND_QUERY, 5, 0));
        send_req(make_req(KIND_INS_AFTER, 5, 5));
        send_req(make_req(KIND_QUERY, 5, 0));
        send_req(make_req(KIND_INS_BEFORE, 6, 6));
        send_req(make_req(KIND_QUERY, 6, 0));
        // placed node still linked: old neighbours keep stale links
        send_req(make_req(KIND_INS_AFTER, 1, 512));
        send_req(make_req(KIND_QUERY, 512, 0));
        send_req(make_req(KIND_QUERY, 1023, 0));
        send_req(make_req(KIND_REMOVE, 512, 1023));
        send_req(make_req(KIND_QUERY, 1, 0));
        send_req(make_req(KIND_REMOVE, 900, 0));
        send_req(make_req(KIND_QUERY, 900, 0));
        send_req(make_req(KIND_REMOVE, 0, 1023));
        send_req(make_req(KIND_REMOVE, 1, 0));
        send_req(make_req(KIND_QUERY, 1023, 0));
        send_req(make_req(KIND_QUERY, 1, 0));

        for (int i = 0; i < 1750; i++)
        begin
            gaps_on = (i >= 500);
            if ($urandom_range(0, 99) < 80)
                send_req(list_req());
            else
                send_req(noise_req());
        end
        start <= 1'b0;

        waited = 0;
        while (sb.neighbours_q.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        if (sb.neighbours_q.size() != 0)
        begin
            $display("%0t: %0d query results never arrived", $time, sb.neighbours_q.size());
            sb.errors++;
        end
        $display("Run covered %0d removes, %0d inserts before, %0d inserts after, %0d queries",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
        $display("%0d query results compared, %0d mismatches", sb.compared, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
